/* rtl/acs_pkg.sv */
// ----------------------------------------------------------------------------
// acs_pkg
// Types and constants shared by the accumulator machine step block.
// ----------------------------------------------------------------------------
package acs_pkg;

    localparam logic [1:0] OPC_WRITE = 2'd0;
    localparam logic [1:0] OPC_READ  = 2'd1;
    localparam logic [1:0] OPC_EXEC  = 2'd2;

    localparam logic [7:0] ADDR_A    = 8'd0;
    localparam logic [7:0] ADDR_X    = 8'd2;
    localparam logic [7:0] ADDR_P    = 8'd3;
    localparam logic [7:0] FLAG_BASE = 8'o201;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] address;
        logic [7:0] write_data;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       halted;
        logic [7:0] program_counter;
    } t_out;

    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] wdata;
    } t_mem_req;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_FETCH,
        ST_BYTE,
        ST_IND_A,
        ST_IND_C,
        ST_X_A,
        ST_X_C,
        ST_OP_A,
        ST_OP_C,
        ST_REG_A,
        ST_REG_C,
        ST_DEC,
        ST_W1,
        ST_W2,
        ST_WP,
        ST_DONE
    } t_state;

endpackage

/* rtl/acs_ram.sv */
// ----------------------------------------------------------------------------
// acs_ram
// 256 x 8 single-port memory with registered read data.
// ----------------------------------------------------------------------------
module acs_ram import acs_pkg::*; (
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [256];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end

endmodule

/* rtl/accumulator_cpu_step.sv */
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// 8-bit accumulator machine with all registers in a 256-byte memory.
//
//   channel | signals                              | payload
//   in      | i_in_valid / o_in_ready / i_in_data   | t_in
//   out     | o_out_valid / i_out_ready / o_out_data | t_out
//
// Write and unused opcode go from idle straight to the result state; a read
// passes through ST_RD first. Execute steps through the chain of reads and
// writes on the single memory port (instruction, second byte, indirect, X,
// operand, register, up to two data writes and the P write).
// After reset a clearing pass zeroes all of memory; no beat is taken.
// A finished result waits in the output register; the next beat is taken.
// ----------------------------------------------------------------------------
module accumulator_cpu_step import acs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_state     r_state, n_state;
    t_mem_req   mem_req;
    logic [7:0] mem_q;
    logic [7:0] r_clr;
    logic [7:0] r_pc, r_pc0, r_ins, r_byte, r_ind, r_x, r_op, r_reg, r_rd;
    logic       r_exec;
    logic       r_out_valid;
    t_out       r_out;

    logic [2:0] lo, mid;
    logic [1:0] hi;
    logic       is_nop, is_sh, is_bit, is_jmp, is_alu;
    logic       need_ind, need_x, need_op, need_reg, need_w1, need_w2;
    logic [7:0] reg_addr, loc, target;
    logic       cond;
    logic [2:0] places;
    logic [15:0] dbl_l, dbl_r;
    logic [7:0] sh_res, mask, bit_res;
    logic       skip_hit;
    logic [8:0] sum9, diff9;
    logic       carry, ovf;
    logic [7:0] w1_addr, w1_data, p_data;
    logic [2:0] p_inc;
    logic       in_acc;

    assign lo  = r_ins[2:0];
    assign mid = r_ins[5:3];
    assign hi  = r_ins[7:6];

    assign is_nop = (lo == 3'd0);
    assign is_sh  = (lo == 3'd1);
    assign is_bit = (lo == 3'd2);
    assign is_jmp = (lo >= 3'd3) && mid[2];
    assign is_alu = (lo >= 3'd3) && !mid[2];

    assign need_ind = (is_jmp && mid[0]) || (is_alu && (lo == 3'd5 || lo == 3'd7));
    assign need_x   = is_alu && lo[2] && lo[1];
    assign need_op  = is_alu;
    assign need_reg = is_sh || is_bit || (is_jmp && hi != 2'd3) || is_alu;

    always_comb begin
        if (is_sh) begin
            reg_addr = {7'd0, mid[2]};
        end else if (is_bit) begin
            reg_addr = r_byte;
        end else if (hi == 2'd3) begin
            reg_addr = ADDR_A;
        end else begin
            reg_addr = {6'd0, hi};
        end
    end

    always_comb begin
        case (lo)
            3'd3:    loc = r_pc0 + 8'd1;
            3'd4:    loc = r_byte;
            3'd5:    loc = r_ind;
            3'd6:    loc = r_x + r_byte;
            default: loc = r_x + r_ind;
        endcase
    end

    assign target = mid[0] ? r_ind : r_byte;

    always_comb begin
        if (hi == 2'd3) begin
            cond = 1'b1;
        end else begin
            case (lo)
                3'd3:    cond = (r_reg != 8'd0);
                3'd4:    cond = (r_reg == 8'd0);
                3'd5:    cond = r_reg[7];
                3'd6:    cond = !r_reg[7];
                default: cond = !r_reg[7] && (r_reg[6:0] != 7'd0);
            endcase
        end
    end

    // shift and rotate
    assign places = (mid[1:0] == 2'd0) ? 3'd4 : {1'b0, mid[1:0]};
    assign dbl_l  = {r_reg, r_reg} << places;
    assign dbl_r  = {r_reg, r_reg} >> places;
    always_comb begin
        case (hi)
            2'd0:    sh_res = r_reg >> places;
            2'd1:    sh_res = dbl_r[7:0];
            2'd2:    sh_res = r_reg << places;
            default: sh_res = dbl_l[15:8];
        endcase
    end

    // bit set, clear and skip
    assign mask     = 8'd1 << mid;
    assign skip_hit = (r_reg[mid] == hi[0]);
    assign bit_res  = hi[0] ? (r_reg | mask) : (r_reg & ~mask);

    // add and subtract
    assign sum9  = {1'b0, r_reg} + {1'b0, r_op};
    assign diff9 = {1'b0, r_reg} - {1'b0, r_op};
    assign carry = mid[0] ? diff9[8] : sum9[8];
    assign ovf   = mid[0] ? ((r_reg[7] != r_op[7]) && (diff9[7] != r_reg[7]))
                          : ((r_reg[7] == r_op[7]) && (sum9[7] != r_reg[7]));

    assign need_w1 = is_sh || (is_bit && !hi[1]) || (is_jmp && cond && mid[1])
                   || (is_alu && !(hi == 2'd3 && mid == 3'd1));
    assign need_w2 = is_alu && (hi != 2'd3) && !mid[1];

    always_comb begin
        w1_addr = reg_addr;
        w1_data = sh_res;
        if (is_bit) begin
            w1_addr = r_byte;
            w1_data = bit_res;
        end else if (is_jmp) begin
            w1_addr = target;
            w1_data = r_pc0 + 8'd2;
        end else if (is_alu) begin
            w1_addr = reg_addr;
            if (hi == 2'd3) begin
                case (mid)
                    3'd0:    w1_data = r_reg | r_op;
                    3'd2:    w1_data = r_reg & r_op;
                    default: w1_data = 8'd0 - r_op;
                endcase
            end else begin
                case (mid)
                    3'd0:    w1_data = sum9[7:0];
                    3'd1:    w1_data = diff9[7:0];
                    3'd2:    w1_data = r_op;
                    default: begin
                        w1_addr = loc;
                        w1_data = r_reg;
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (is_nop || is_sh || (is_alu && hi == 2'd3 && mid == 3'd1)) begin
            p_inc = 3'd1;
        end else if (is_bit && hi[1] && skip_hit) begin
            p_inc = 3'd4;
        end else begin
            p_inc = 3'd2;
        end
        if (is_jmp && cond) begin
            p_data = mid[1] ? target + 8'd1 : target;
        end else begin
            p_data = r_pc + {5'd0, p_inc};
        end
    end

    function automatic t_state first_after(input logic [1:0] lvl, input logic ind,
                                           input logic x, input logic op,
                                           input logic rg);
        t_state s;
        s = ST_DEC;
        if (lvl == 2'd0 && ind) begin
            s = ST_IND_A;
        end else if (lvl <= 2'd1 && x) begin
            s = ST_X_A;
        end else if (lvl <= 2'd2 && op) begin
            s = ST_OP_A;
        end else if (rg) begin
            s = ST_REG_A;
        end
        return s;
    endfunction

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state       = r_state;
        mem_req.we    = 1'b0;
        mem_req.addr  = r_pc;
        mem_req.wdata = 8'd0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_req.we   = 1'b1;
                mem_req.addr = r_clr;
                if (r_clr == 8'hff) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.opcode)
                        OPC_WRITE: begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = i_in_data.address;
                            mem_req.wdata = i_in_data.write_data;
                            n_state       = ST_DONE;
                        end
                        OPC_READ: begin
                            mem_req.addr = i_in_data.address;
                            n_state      = ST_RD;
                        end
                        OPC_EXEC: begin
                            mem_req.addr = r_pc;
                            n_state      = ST_FETCH;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_RD:    n_state = ST_DONE;
            ST_FETCH: begin
                mem_req.addr = r_pc0 + 8'd1;
                n_state      = ST_BYTE;
            end
            ST_BYTE:  n_state = first_after(2'd0, need_ind, need_x, need_op, need_reg);
            ST_IND_A: begin
                mem_req.addr = r_byte;
                n_state      = ST_IND_C;
            end
            ST_IND_C: n_state = first_after(2'd1, need_ind, need_x, need_op, need_reg);
            ST_X_A: begin
                mem_req.addr = ADDR_X;
                n_state      = ST_X_C;
            end
            ST_X_C:   n_state = first_after(2'd2, need_ind, need_x, need_op, need_reg);
            ST_OP_A: begin
                mem_req.addr = loc;
                n_state      = ST_OP_C;
            end
            ST_OP_C:  n_state = first_after(2'd3, need_ind, need_x, 1'b0, need_reg);
            ST_REG_A: begin
                mem_req.addr = reg_addr;
                n_state      = ST_REG_C;
            end
            ST_REG_C: n_state = ST_DEC;
            ST_DEC: begin
                if (need_w1) begin
                    n_state = ST_W1;
                end else if (need_w2) begin
                    n_state = ST_W2;
                end else begin
                    n_state = ST_WP;
                end
            end
            ST_W1: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = w1_addr;
                mem_req.wdata = w1_data;
                n_state       = need_w2 ? ST_W2 : ST_WP;
            end
            ST_W2: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = FLAG_BASE + {6'd0, hi};
                mem_req.wdata = {6'd0, carry, ovf};
                n_state       = ST_WP;
            end
            ST_WP: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = ADDR_P;
                mem_req.wdata = p_data;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    acs_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= 8'd0;
            r_pc        <= 8'd0;
            r_out_valid <= 1'b0;
            r_exec      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 8'd1;
            // mirror P so increments see the latest write to it
            if (mem_req.we && mem_req.addr == ADDR_P) r_pc <= mem_req.wdata;
            if (in_acc) r_exec <= (i_in_data.opcode == OPC_EXEC);
            if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pc0 <= r_pc;
            r_rd  <= 8'd0;
        end
        case (r_state)
            ST_RD:    r_rd   <= mem_q;
            ST_FETCH: r_ins  <= mem_q;
            ST_BYTE:  r_byte <= mem_q;
            ST_IND_C: r_ind  <= mem_q;
            ST_X_C:   r_x    <= mem_q;
            ST_OP_C:  r_op   <= mem_q;
            ST_REG_C: r_reg  <= mem_q;
            default: ;
        endcase
        if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) begin
            r_out.read_data       <= r_rd;
            r_out.halted          <= r_exec && is_nop && !hi[1];
            r_out.program_counter <= r_pc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_in_ready)
        else $error("input beat offered during clearing pass");

    a_pc_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.opcode == OPC_WRITE && i_in_data.address == ADDR_P)
        |=> (r_pc == $past(i_in_data.write_data)))
        else $error("P mirror missed a write");

    a_halt_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.halted) |-> (o_out_data.read_data == 8'd0))
        else $error("halt beat carries read data");

    a_pwrite_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WP) |=> (r_state == ST_DONE))
        else $error("P write not followed by result");

endmodule
